[hw/rtl/bmpw_pkg.sv]
// shared types, constants and header byte lookup for the bmp24 stream writer
package bmpw_pkg;

    localparam int MAX_WIDTH   = 16384;
    localparam int MAX_HEIGHT  = 16384;
    localparam int DIM_W       = 15;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int HDR_LEN     = 54;
    localparam int HDR_CNT_W   = $clog2(HDR_LEN);
    localparam int DATA_OFFSET = 54;
    localparam int INFO_SIZE   = 40;
    localparam int BIT_COUNT   = 24;
    localparam int PLANES      = 1;
    localparam int ROWB_W      = 16;
    localparam int PROD_W      = ROWB_W + DIM_W;
    localparam int FSIZE_W     = 32;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef logic [7:0] pix_byte_t;
    typedef logic [DIM_W-1:0] dim_t;

    typedef enum logic [2:0] {
        FMT_BGR  = 3'd0,
        FMT_RGB  = 3'd1,
        FMT_BGRA = 3'd2,
        FMT_RGBA = 3'd3,
        FMT_ABGR = 3'd4,
        FMT_ARGB = 3'd5
    } fmt_t;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_FORMAT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_HEAD  = 2'd0,
        ST_PIXEL = 2'd1,
        ST_PAD   = 2'd2
    } back_state_t;

    typedef struct packed {
        logic      hdr;
        pix_byte_t blue;
        pix_byte_t green;
        pix_byte_t red;
        logic [1:0] pad;
        logic      image_end;
    } entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    function automatic dim_t clamp_dim(input dim_t v, input dim_t maxv);
        dim_t r;
        if (v == '0)
        begin
            r = dim_t'(1);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic pix_byte_t header_byte(input logic [HDR_CNT_W-1:0] idx, input dim_t w,
                                              input dim_t h, input logic [FSIZE_W-1:0] fsize);
        logic [31:0] w32;
        logic [31:0] nh32;
        pix_byte_t   r;
        w32  = 32'(w);
        nh32 = 32'd0 - 32'(h);
        unique case (idx)
            6'd0:    r = 8'h42;
            6'd1:    r = 8'h4D;
            6'd2:    r = fsize[7:0];
            6'd3:    r = fsize[15:8];
            6'd4:    r = fsize[23:16];
            6'd5:    r = fsize[31:24];
            6'd10:   r = 8'(DATA_OFFSET);
            6'd14:   r = 8'(INFO_SIZE);
            6'd18:   r = w32[7:0];
            6'd19:   r = w32[15:8];
            6'd20:   r = w32[23:16];
            6'd21:   r = w32[31:24];
            6'd22:   r = nh32[7:0];
            6'd23:   r = nh32[15:8];
            6'd24:   r = nh32[23:16];
            6'd25:   r = nh32[31:24];
            6'd26:   r = 8'(PLANES);
            6'd28:   r = 8'(BIT_COUNT);
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/bmpw_front.sv]
// front part: pixel acceptance, byte reordering and row/image position tracking
module bmpw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bmpw_pkg::pix_byte_t byte0,
    input  bmpw_pkg::pix_byte_t byte1,
    input  bmpw_pkg::pix_byte_t byte2,
    input  bmpw_pkg::pix_byte_t byte3,
    input  bmpw_pkg::dim_t    w,
    input  bmpw_pkg::dim_t    h,
    input  logic [2:0]        fmt,
    input  bmpw_pkg::q_status_t q_status,
    output logic              push,
    output bmpw_pkg::entry_t  entry
);
    import bmpw_pkg::*;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             hdr_sent_reg;
    logic             hdr_sent_next;
    logic             row_end;
    logic             image_end;

    assign in_stall  = q_status.full;
    assign push      = in_valid && !q_status.full;
    assign row_end   = (DIM_W'(col_reg) + DIM_W'(1)) >= w;
    assign image_end = row_end && ((DIM_W'(row_reg) + DIM_W'(1)) >= h);

    always_comb
    begin
        entry.hdr       = !hdr_sent_reg;
        entry.pad       = row_end ? w[1:0] : 2'd0;
        entry.image_end = image_end;
        unique case (fmt_t'(fmt))
            FMT_RGB, FMT_RGBA:
            begin
                entry.blue  = byte2;
                entry.green = byte1;
                entry.red   = byte0;
            end
            FMT_ABGR:
            begin
                entry.blue  = byte1;
                entry.green = byte2;
                entry.red   = byte3;
            end
            FMT_ARGB:
            begin
                entry.blue  = byte3;
                entry.green = byte2;
                entry.red   = byte1;
            end
            default:
            begin
                entry.blue  = byte0;
                entry.green = byte1;
                entry.red   = byte2;
            end
        endcase
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        hdr_sent_next = hdr_sent_reg;
        if (push)
        begin
            hdr_sent_next = 1'b1;
            if (row_end)
            begin
                col_next = '0;
                if (image_end)
                begin
                    row_next      = '0;
                    hdr_sent_next = 1'b0;
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            hdr_sent_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            hdr_sent_reg <= hdr_sent_next;
        end
    end

endmodule

[hw/rtl/bmpw_queue.sv]
// short fifo of classified pixels between front and back
module bmpw_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bmpw_pkg::entry_t   wr_entry,
    input  logic               pop,
    output bmpw_pkg::entry_t   head,
    output bmpw_pkg::q_status_t q_status
);
    import bmpw_pkg::*;

    entry_t            slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head               = slot_reg[rd_ptr_reg];
    assign q_status.full      = (count_reg == QCNT_W'(QDEPTH));
    assign q_status.not_empty = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/bmpw_back.sv]
// back part: header, pixel and padding byte sequencer with output register
module bmpw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bmpw_pkg::entry_t    head,
    input  logic                head_valid,
    output logic                pop,
    input  bmpw_pkg::dim_t      w,
    input  bmpw_pkg::dim_t      h,
    output logic                out_valid,
    input  logic                out_stall,
    output bmpw_pkg::pix_byte_t out_byte,
    output logic                last_of_item,
    output logic                end_of_image
);
    import bmpw_pkg::*;

    back_state_t          state_reg;
    back_state_t          state_next;
    back_state_t          phase;
    logic [HDR_CNT_W-1:0] cnt_reg;
    logic [HDR_CNT_W-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    pix_byte_t            out_byte_reg;
    logic                 last_reg;
    logic                 eoi_reg;
    logic [FSIZE_W-1:0]   fsize_reg;
    logic [ROWB_W-1:0]    row_bytes;
    logic [PROD_W-1:0]    prod;
    logic                 advance;
    logic                 done;
    pix_byte_t            byte_sel;

    // bytes per padded row, then total file size
    assign row_bytes = ROWB_W'({w, 1'b0}) + ROWB_W'(w) + ROWB_W'(w[1:0]);
    assign prod      = PROD_W'(row_bytes) * PROD_W'(h);

    always_ff @(posedge clk)
    begin
        fsize_reg <= FSIZE_W'(prod) + FSIZE_W'(HDR_LEN);
    end

    assign advance = head_valid && (!out_valid_reg || !out_stall);
    assign pop     = advance && done;

    always_comb
    begin
        phase = state_reg;
        if (state_reg == ST_HEAD && !head.hdr)
        begin
            phase = ST_PIXEL;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        byte_sel   = 8'h00;
        unique case (phase)
            ST_HEAD:
            begin
                byte_sel = header_byte(cnt_reg, w, h, fsize_reg);
                if (cnt_reg == HDR_CNT_W'(HDR_LEN - 1))
                begin
                    state_next = ST_PIXEL;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + HDR_CNT_W'(1);
                end
            end
            ST_PIXEL:
            begin
                if (cnt_reg == HDR_CNT_W'(0))
                begin
                    byte_sel = head.blue;
                end
                else if (cnt_reg == HDR_CNT_W'(1))
                begin
                    byte_sel = head.green;
                end
                else
                begin
                    byte_sel = head.red;
                end
                if (cnt_reg == HDR_CNT_W'(2))
                begin
                    cnt_next = '0;
                    if (head.pad == 2'd0)
                    begin
                        done       = 1'b1;
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        state_next = ST_PAD;
                    end
                end
                else
                begin
                    state_next = ST_PIXEL;
                    cnt_next   = cnt_reg + HDR_CNT_W'(1);
                end
            end
            ST_PAD:
            begin
                byte_sel = 8'h00;
                if (cnt_reg[1:0] == head.pad - 2'd1)
                begin
                    done       = 1'b1;
                    state_next = ST_HEAD;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + HDR_CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_HEAD;
                cnt_next   = '0;
            end
        endcase
        if (!advance)
        begin
            state_next = state_reg;
            cnt_next   = cnt_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HEAD;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_sel;
            last_reg     <= done;
            eoi_reg      <= done && head.image_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last_of_item = last_reg;
    assign end_of_image = eoi_reg;

endmodule

[hw/rtl/bmp24_stream_writer_unit.sv]
// Streams a 24-bit top-down BMP file one byte per beat from pixels given one per beat in
// raster order. Output moves one byte per cycle while a pixel is queued and out_stall is
// low: 3 bytes per pixel, up to 3 pad bytes per row end and 54 header bytes before each
// image's first pixel. A four-entry queue decouples pixel intake from the byte
// sequencer, so pixels are taken while earlier ones are still being sent. Width and
// height are clamped to 1..16384. Registers must be written only while no pixel is in
// flight; the block does not enforce this. A write between two pixels of an image
// applies from the next pixel on, and a header already sent stays as it was.
module bmp24_stream_writer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [14:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte0,
    input  logic [7:0] byte1,
    input  logic [7:0] byte2,
    input  logic [7:0] byte3,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_item,
    output logic       end_of_image
);
    import bmpw_pkg::*;

    dim_t       width_reg;
    dim_t       height_reg;
    logic [2:0] format_reg;
    dim_t       w_eff;
    dim_t       h_eff;
    logic       push;
    logic       pop;
    entry_t     wr_entry;
    entry_t     head;
    q_status_t  q_status;

    assign cfg_ready = 1'b1;
    assign w_eff     = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign h_eff     = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            format_reg <= FMT_BGR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_FORMAT: format_reg <= cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    bmpw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .byte0    (byte0),
        .byte1    (byte1),
        .byte2    (byte2),
        .byte3    (byte3),
        .w        (w_eff),
        .h        (h_eff),
        .fmt      (format_reg),
        .q_status (q_status),
        .push     (push),
        .entry    (wr_entry)
    );

    bmpw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    bmpw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (q_status.not_empty),
        .pop          (pop),
        .w            (w_eff),
        .h            (h_eff),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .end_of_image (end_of_image)
    );

    a_eoi_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_image |-> last_of_item)
        else $error("end of image without last byte of pixel");

    a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_status.not_empty))
        else $error("output beat without a queued pixel");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.not_empty)
        else $error("queue popped while empty");

endmodule

[bench/bmp24_byte_stream_checker.sv]
// checker that predicts the bmp byte stream from register and pixel beats and compares it
module bmp24_byte_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  byte0,
    input  logic [7:0]  byte1,
    input  logic [7:0]  byte2,
    input  logic [7:0]  byte3,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        last_of_item,
    input  logic        end_of_image,
    output int          mismatches,
    output int          bytes_owed
);
    import bmpw_pkg::*;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       eoi;
    } file_byte_t;

    file_byte_t  owed_bytes[$];
    int          err_count;
    dim_t        img_width;
    dim_t        img_height;
    logic [2:0]  pix_fmt;
    int unsigned col_pos;
    int unsigned row_pos;
    logic        header_done;

    assign mismatches = err_count;

    function automatic int unsigned bound_dim(input dim_t v, input int unsigned maxv);
        int unsigned r;
        r = 32'(v);
        if (r == 0)
        begin
            r = 1;
        end
        else if (r > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    function automatic void predict_pixel_bytes(input logic [7:0] b0, input logic [7:0] b1,
                                                input logic [7:0] b2, input logic [7:0] b3);
        int unsigned     w;
        int unsigned     h;
        int unsigned     pad;
        longint unsigned fsize_full;
        logic [31:0]     fsize;
        logic [31:0]     w32;
        logic [31:0]     neg_h;
        logic [7:0]      hdr[HDR_LEN];
        logic [7:0]      blue;
        logic [7:0]      green;
        logic [7:0]      red;
        logic            row_end;
        logic            image_end;
        w = bound_dim(img_width, MAX_WIDTH);
        h = bound_dim(img_height, MAX_HEIGHT);
        pad = (4 - ((3 * w) & 3)) & 3;
        if (!header_done)
        begin
            fsize_full = 64'(HDR_LEN) + 64'(3 * w + pad) * 64'(h);
            fsize = fsize_full[31:0];
            w32 = 32'(w);
            neg_h = 32'd0 - 32'(h);
            foreach (hdr[i])
            begin
                hdr[i] = 8'h00;
            end
            hdr[0] = "B";
            hdr[1] = "M";
            for (int i = 0; i < 4; i++)
            begin
                hdr[2 + i]  = fsize[8 * i +: 8];
                hdr[10 + i] = 8'(DATA_OFFSET >> (8 * i));
                hdr[14 + i] = 8'(INFO_SIZE >> (8 * i));
                hdr[18 + i] = w32[8 * i +: 8];
                hdr[22 + i] = neg_h[8 * i +: 8];
            end
            hdr[26] = 8'(PLANES);
            hdr[28] = 8'(BIT_COUNT);
            foreach (hdr[i])
            begin
                owed_bytes.push_back('{hdr[i], 1'b0, 1'b0});
            end
            header_done = 1'b1;
        end
        case (pix_fmt)
            FMT_RGB, FMT_RGBA:
            begin
                blue = b2; green = b1; red = b0;
            end
            FMT_ABGR:
            begin
                blue = b1; green = b2; red = b3;
            end
            FMT_ARGB:
            begin
                blue = b3; green = b2; red = b1;
            end
            default:
            begin
                blue = b0; green = b1; red = b2;
            end
        endcase
        owed_bytes.push_back('{blue, 1'b0, 1'b0});
        owed_bytes.push_back('{green, 1'b0, 1'b0});
        owed_bytes.push_back('{red, 1'b0, 1'b0});
        row_end = (col_pos + 1) >= w;
        image_end = row_end && ((row_pos + 1) >= h);
        if (row_end)
        begin
            for (int k = 0; k < pad; k++)
            begin
                owed_bytes.push_back('{8'h00, 1'b0, 1'b0});
            end
            col_pos = 0;
            if (image_end)
            begin
                row_pos = 0;
                header_done = 1'b0;
            end
            else
            begin
                row_pos = row_pos + 1;
            end
        end
        else
        begin
            col_pos = col_pos + 1;
        end
        owed_bytes[owed_bytes.size() - 1].last = 1'b1;
        owed_bytes[owed_bytes.size() - 1].eoi = image_end;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        file_byte_t exp_byte;
        if (!rst_n)
        begin
            owed_bytes.delete();
            err_count = 0;
            img_width = dim_t'(1);
            img_height = dim_t'(1);
            pix_fmt = FMT_BGR;
            col_pos = 0;
            row_pos = 0;
            header_done = 1'b0;
            bytes_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:  img_width = cfg_data;
                    CFG_HEIGHT: img_height = cfg_data;
                    CFG_FORMAT: pix_fmt = cfg_data[2:0];
                    default:    ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (owed_bytes.size() == 0)
                begin
                    $error("out_byte: expected nothing, actual %02h", out_byte);
                    err_count++;
                end
                else
                begin
                    exp_byte = owed_bytes.pop_front();
                    if (out_byte !== exp_byte.value)
                    begin
                        $error("out_byte: expected %02h, actual %02h", exp_byte.value, out_byte);
                        err_count++;
                    end
                    if (last_of_item !== exp_byte.last)
                    begin
                        $error("last_of_item: expected %0b, actual %0b", exp_byte.last,
                               last_of_item);
                        err_count++;
                    end
                    if (end_of_image !== exp_byte.eoi)
                    begin
                        $error("end_of_image: expected %0b, actual %0b", exp_byte.eoi,
                               end_of_image);
                        err_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_pixel_bytes(byte0, byte1, byte2, byte3);
            end
            bytes_owed <= owed_bytes.size();
        end
    end

endmodule

[bench/bmp24_stream_writer_unit_tb.sv]
// testbench top for the bmp24 stream writer: clock, reset, pixel and register stimulus, verdict
module bmp24_stream_writer_unit_tb;
    import bmpw_pkg::*;

    localparam logic [1:0] CFG_SPARE    = 2'd3;
    localparam logic [2:0] FMT_SPARE_LO = 3'd6;
    localparam logic [2:0] FMT_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER  = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_WIDTH;
    logic [14:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  byte0 = 8'h00;
    logic [7:0]  byte1 = 8'h00;
    logic [7:0]  byte2 = 8'h00;
    logic [7:0]  byte3 = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_item;
    logic        end_of_image;

    int mismatches;
    int bytes_owed;
    int send_idle = 17;
    int recv_idle = 50;
    int pixels_taken = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int cycle_count = 0;

    bmp24_stream_writer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte0        (byte0),
        .byte1        (byte1),
        .byte2        (byte2),
        .byte3        (byte3),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .end_of_image (end_of_image)
    );

    bmp24_byte_stream_checker stream_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte0        (byte0),
        .byte1        (byte1),
        .byte2        (byte2),
        .byte3        (byte3),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_item (last_of_item),
        .end_of_image (end_of_image),
        .mismatches   (mismatches),
        .bytes_owed   (bytes_owed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("bmp24_stream_writer_unit test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            pixels_taken <= pixels_taken + 1;
        end
    end

    // receiver side, with one long hold-off while pixels are still being offered
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && in_valid && pixels_taken >= HOLD_AFTER)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic offer_pixel(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input logic [7:0] b3);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte0 <= b0;
        byte1 <= b1;
        byte2 <= b2;
        byte3 <= b3;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic offer_random_pixel();
        offer_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bytes_owed != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_image(input logic [14:0] w, input logic [14:0] h, input logic [2:0] f);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_FORMAT, 15'(f));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int done_pixels;
        int n_pix;
        int pick;
        logic [14:0] w;
        logic [14:0] h;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: one-pixel images
        offer_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        offer_pixel(8'hff, 8'hff, 8'hff, 8'hff);
        wait_drained();

        // zero sizes and undefined formats
        set_image(15'd0, 15'd0, FMT_SPARE_LO);
        offer_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        wait_drained();
        set_image(15'd1, 15'd1, FMT_SPARE_HI);
        offer_pixel(8'h9a, 8'hbc, 8'hde, 8'hf0);
        wait_drained();

        for (int f = FMT_RGB; f <= FMT_ARGB; f++)
        begin
            set_image(15'd1, 15'd1, 3'(f));
            offer_pixel(8'ha1, 8'hb2, 8'hc3, 8'hd4);
            wait_drained();
        end

        // oversize dims saturate, then shrink mid-image to close the file
        set_image(15'h7fff, 15'h7fff, FMT_BGR);
        offer_random_pixel();
        wait_drained();
        write_reg(CFG_SPARE, 15'h7fff);
        set_image(15'd1, 15'd1, FMT_BGR);
        offer_random_pixel();
        wait_drained();

        set_image(15'd16384, 15'd16384, FMT_BGRA);
        offer_random_pixel();
        wait_drained();
        set_image(15'd1, 15'd1, FMT_BGRA);
        offer_random_pixel();
        wait_drained();

        // width cut below the column counter ends the row early
        set_image(15'd3, 15'd2, FMT_BGR);
        offer_random_pixel();
        offer_random_pixel();
        wait_drained();
        set_image(15'd2, 15'd2, FMT_BGR);
        repeat (3) offer_random_pixel();
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 17 : (ph == 1) ? 50 : 0;
            recv_idle <= (ph == 0) ? 50 : (ph == 1) ? 17 : 0;
            done_pixels = 0;
            if (ph == 0)
            begin
                set_image(15'd20, 15'd2, 3'($urandom_range(7)));
                repeat (40) offer_random_pixel();
                wait_drained();
                done_pixels = 40;
            end
            while (done_pixels < 35)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                begin
                    w = 15'd0;
                    h = 15'($urandom_range(0, 3));
                end
                else if (pick < 85)
                begin
                    w = 15'($urandom_range(1, 8));
                    h = 15'($urandom_range(0, 4));
                end
                else
                begin
                    w = 15'($urandom_range(9, 32));
                    h = 15'($urandom_range(1, 2));
                end
                set_image(w, h, 3'($urandom_range(7)));
                n_pix = ((w == 0) ? 1 : int'(w)) * ((h == 0) ? 1 : int'(h));
                // now and then stop partway so the next setting lands mid-image
                if ($urandom_range(9) == 0)
                begin
                    n_pix = $urandom_range(1, n_pix);
                end
                repeat (n_pix) offer_random_pixel();
                wait_drained();
                done_pixels += n_pix;
            end
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && bytes_owed == 0)
        begin
            $display("bmp24_stream_writer_unit test passed");
        end
        else
        begin
            $display("bmp24_stream_writer_unit test failed");
        end
        $finish;
    end

endmodule

[bmp24_stream_writer_unit.f]
hw/rtl/bmpw_pkg.sv
hw/rtl/bmpw_front.sv
hw/rtl/bmpw_queue.sv
hw/rtl/bmpw_back.sv
hw/rtl/bmp24_stream_writer_unit.sv
bench/bmp24_byte_stream_checker.sv
bench/bmp24_stream_writer_unit_tb.sv
